FILE: src/q2e_pkg.sv
`default_nettype none

package q2e_pkg;

  localparam int ITERS    = 16;
  localparam int SQ_STEPS = 29;
  localparam int CW       = 38;
  localparam int AW       = 33;

  localparam logic [1:0] MODE_DRIVE = 2'd0;
  localparam logic [1:0] MODE_ARM_A = 2'd1;
  localparam logic [1:0] MODE_CLAW  = 2'd2;
  localparam logic [1:0] MODE_ARM_B = 2'd3;

  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  localparam logic signed [AW-1:0] ANG_PI      = 33'sh0_8000_0000;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 33'sh0_4000_0000;

  typedef struct packed {
    logic               is_roll;
    logic               do_yaw;
    logic signed [34:0] my;
    logic signed [34:0] mx;
    logic signed [34:0] ya;
    logic signed [34:0] yb;
  } side_t;

  typedef struct packed {
    logic [57:0] v;
    logic [57:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 spec;
    logic signed [AW-1:0] sang;
  } cord_t;

  function automatic cord_t cord_init(input logic signed [34:0] y, input logic signed [34:0] x);
    cord_t c;
    c.x    = CW'(x);
    c.y    = CW'(y);
    c.z    = 32'h0;
    c.spec = 1'b0;
    c.sang = '0;
    if (y == 35'sd0) begin
      c.spec = 1'b1;
      c.sang = (x < 35'sd0) ? ANG_PI : '0;
    end else if (x == 35'sd0) begin
      c.spec = 1'b1;
      c.sang = (y > 35'sd0) ? ANG_HALF_PI : -ANG_HALF_PI;
    end else if (x < 35'sd0) begin
      c.x = -CW'(x);
      c.y = -CW'(y);
      c.z = 32'h8000_0000;
    end
    return c;
  endfunction

  function automatic cord_t cord_iter(input cord_t c, input int i);
    cord_t n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    n  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + ATAN_TAB[i];
    end else begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - ATAN_TAB[i];
    end
    return n;
  endfunction

  function automatic logic signed [AW-1:0] cord_angle(input cord_t c);
    logic signed [AW-1:0] a;
    if (c.spec) begin
      a = c.sang;
    end else if (c.z == 32'h8000_0000) begin
      a = ANG_PI;
    end else begin
      a = {c.z[31], c.z};
    end
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: src/quaternion_to_euler_bins_core.sv
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+------------------------
// item in  | quat_w/x/y/z_i, control_mode_i, system_unlocked_i | start & !busy
// item out | roll/pitch/yaw _valid_o and _bin_o             | done_o, one cycle
//
// one item a cycle; each item passes the product, sum, square, square-root, cordic, angle and output registers in turn
// depth set mainly by the 29 square-root stages and 16 cordic stages, one step each
// reset clears every valid bit; busy is high only during reset
// no stalls: the receiver takes every item in the cycle it is shown
`default_nettype none

module quaternion_to_euler_bins_core
  import q2e_pkg::*;
#(
  parameter int BIN_COUNT = 18
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic [1:0]         control_mode_i,
  input  wire logic               system_unlocked_i,
  output logic                    done_o,
  output logic                    roll_valid_o,
  output logic signed [5:0]       roll_bin_o,
  output logic                    pitch_valid_o,
  output logic [4:0]              pitch_bin_o,
  output logic                    yaw_valid_o,
  output logic [4:0]              yaw_bin_o
);

  localparam int BW      = $clog2(BIN_COUNT + 1) + 1;
  localparam int PW      = 34 + BW;
  localparam int LATENCY = 4 + SQ_STEPS + 1 + ITERS + 2;

  logic accept;
  assign busy   = !rst_ni;
  assign accept = start && !busy;

  // stage 1: products
  logic s1_vld_q, s1_roll_q, s1_yaw_q;
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q, p_zx_q, p_wz_q, p_xy_q, p_zz_q;

  // stage 2: sums
  logic s2_vld_q;
  side_t s2_sd_q;
  logic signed [29:0] s2_s_q;
  logic signed [33:0] ra, psr, ya;
  logic signed [34:0] rb, yb;
  logic signed [29:0] ps;

  // stage 3: square
  logic s3_vld_q;
  side_t s3_sd_q;
  logic [56:0] s3_ss_q;
  logic signed [57:0] ss_full;

  // square-root stages
  logic  sq_vld_q [SQ_STEPS+1];
  side_t sq_sd_q  [SQ_STEPS+1];
  sq_t   sq_q     [SQ_STEPS+1];

  // cordic stages, main lane and yaw lane
  logic  cr_vld_q  [ITERS+1];
  logic  cr_roll_q [ITERS+1];
  logic  cr_yaw_q  [ITERS+1];
  cord_t cm_q      [ITERS+1];
  cord_t cy_q      [ITERS+1];

  // angle stage
  logic an_vld_q, an_roll_q, an_yaw_q;
  logic signed [AW-1:0] an_m_q, an_y_q;

  always_comb begin
    ra  = (34'(p_wx_q) + 34'(p_yz_q)) <<< 1;
    rb  = 35'sd268435456 - ((35'(p_xx_q) + 35'(p_yy_q)) <<< 1);
    psr = (34'(p_wy_q) - 34'(p_zx_q)) <<< 1;
    ya  = (34'(p_wz_q) + 34'(p_xy_q)) <<< 1;
    yb  = 35'sd268435456 - ((35'(p_yy_q) + 35'(p_zz_q)) <<< 1);
    if (psr > 34'sd268435456) begin
      ps = 30'sd268435456;
    end else if (psr < -34'sd268435456) begin
      ps = -30'sd268435456;
    end else begin
      ps = psr[29:0];
    end
    ss_full = s2_s_q * s2_s_q;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) sq_vld_q[k] <= 1'b0;
      for (int k = 0; k <= ITERS; k++) cr_vld_q[k] <= 1'b0;
      an_vld_q <= 1'b0;
    end else begin
      s1_vld_q    <= accept;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      sq_vld_q[0] <= s3_vld_q;
      for (int k = 1; k <= SQ_STEPS; k++) sq_vld_q[k] <= sq_vld_q[k-1];
      cr_vld_q[0] <= sq_vld_q[SQ_STEPS];
      for (int k = 1; k <= ITERS; k++) cr_vld_q[k] <= cr_vld_q[k-1];
      an_vld_q <= cr_vld_q[ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_roll_q <= (control_mode_i == MODE_CLAW) && system_unlocked_i;
    s1_yaw_q  <= (control_mode_i == MODE_DRIVE) && system_unlocked_i;
    p_wx_q    <= quat_w_i * quat_x_i;
    p_yz_q    <= quat_y_i * quat_z_i;
    p_xx_q    <= quat_x_i * quat_x_i;
    p_yy_q    <= quat_y_i * quat_y_i;
    p_wy_q    <= quat_w_i * quat_y_i;
    p_zx_q    <= quat_z_i * quat_x_i;
    p_wz_q    <= quat_w_i * quat_z_i;
    p_xy_q    <= quat_x_i * quat_y_i;
    p_zz_q    <= quat_z_i * quat_z_i;

    s2_sd_q.is_roll <= s1_roll_q;
    s2_sd_q.do_yaw  <= s1_yaw_q;
    s2_sd_q.my      <= s1_roll_q ? 35'(ra) : 35'(ps);
    s2_sd_q.mx      <= rb;
    s2_sd_q.ya      <= 35'(ya);
    s2_sd_q.yb      <= yb;
    s2_s_q          <= ps;

    s3_sd_q <= s2_sd_q;
    s3_ss_q <= ss_full[56:0];

    sq_sd_q[0] <= s3_sd_q;
    sq_q[0].v  <= (58'd1 << 56) - {1'b0, s3_ss_q};
    sq_q[0].r  <= '0;
  end

  // one root bit a stage
  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    localparam logic [57:0] SQ_BIT = 58'd1 << (2 * (SQ_STEPS - k));
    logic [57:0] trial;
    assign trial = sq_q[k-1].r + SQ_BIT;
    always_ff @(posedge clk_i) begin
      sq_sd_q[k] <= sq_sd_q[k-1];
      if (sq_q[k-1].v >= trial) begin
        sq_q[k].v <= sq_q[k-1].v - trial;
        sq_q[k].r <= (sq_q[k-1].r >> 1) + SQ_BIT;
      end else begin
        sq_q[k].v <= sq_q[k-1].v;
        sq_q[k].r <= sq_q[k-1].r >> 1;
      end
    end
  end

  logic signed [34:0] m_x;
  assign m_x = sq_sd_q[SQ_STEPS].is_roll ? sq_sd_q[SQ_STEPS].mx
                                         : {6'b0, sq_q[SQ_STEPS].r[28:0]};

  always_ff @(posedge clk_i) begin
    cr_roll_q[0] <= sq_sd_q[SQ_STEPS].is_roll;
    cr_yaw_q[0]  <= sq_sd_q[SQ_STEPS].do_yaw;
    cm_q[0]      <= cord_init(sq_sd_q[SQ_STEPS].my, m_x);
    cy_q[0]      <= cord_init(sq_sd_q[SQ_STEPS].ya, sq_sd_q[SQ_STEPS].yb);
  end

  for (genvar i = 1; i <= ITERS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      cr_roll_q[i] <= cr_roll_q[i-1];
      cr_yaw_q[i]  <= cr_yaw_q[i-1];
      cm_q[i]      <= cord_iter(cm_q[i-1], i - 1);
      cy_q[i]      <= cord_iter(cy_q[i-1], i - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    an_roll_q <= cr_roll_q[ITERS];
    an_yaw_q  <= cr_yaw_q[ITERS];
    an_m_q    <= cord_angle(cm_q[ITERS]);
    an_y_q    <= cord_angle(cy_q[ITERS]);
  end

  // binning
  logic signed [33:0]   m_off, y_off;
  logic signed [PW-1:0] m_prod, y_prod, m_adj;
  logic signed [PW-1:0] m_bin, y_bin;
  logic signed [5:0]    roll_d;
  logic [4:0]           pitch_d, yaw_d;

  always_comb begin
    m_off  = 34'(an_m_q) + 34'sd1073741824;
    y_off  = 34'(an_y_q) + 34'sd2147483648;
    m_prod = PW'(m_off) * PW'(BIN_COUNT);
    y_prod = PW'(y_off) * PW'(BIN_COUNT);
    m_adj  = (m_prod < 0) ? (m_prod + PW'(64'sd2147483647)) : m_prod;
    m_bin  = m_adj >>> 31;
    y_bin  = y_prod >>> 32;
    if (m_bin > PW'(31)) begin
      roll_d = 6'sd31;
    end else if (m_bin < -PW'(32)) begin
      roll_d = -6'sd32;
    end else begin
      roll_d = m_bin[5:0];
    end
    if (m_bin > PW'(31)) begin
      pitch_d = 5'd31;
    end else if (m_bin < 0) begin
      pitch_d = 5'd0;
    end else begin
      pitch_d = m_bin[4:0];
    end
    if (y_bin > PW'(31)) begin
      yaw_d = 5'd31;
    end else if (y_bin < 0) begin
      yaw_d = 5'd0;
    end else begin
      yaw_d = y_bin[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o        <= 1'b0;
      roll_valid_o  <= 1'b0;
      pitch_valid_o <= 1'b0;
      yaw_valid_o   <= 1'b0;
      roll_bin_o    <= '0;
      pitch_bin_o   <= '0;
      yaw_bin_o     <= '0;
    end else begin
      done_o        <= an_vld_q;
      roll_valid_o  <= an_vld_q && an_roll_q;
      pitch_valid_o <= an_vld_q && !an_roll_q;
      yaw_valid_o   <= an_vld_q && an_yaw_q;
      roll_bin_o    <= an_roll_q ? roll_d : 6'sd0;
      pitch_bin_o   <= an_roll_q ? 5'd0 : pitch_d;
      yaw_bin_o     <= an_yaw_q ? yaw_d : 5'd0;
    end
  end

  a_one_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_valid_o ^ pitch_valid_o))
    else $error("roll and pitch both or neither computed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("item did not leave after the pipeline depth");

  a_yaw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_valid_o |-> (!roll_valid_o && done_o))
    else $error("yaw alongside roll or without an item");

endmodule

`default_nettype wire
